>>> hw/rtl/eeoc_pkg.sv
// Shared types, constants and the phase lookup for the encoder electrical offset calibrator.
// No dependencies; used by eeoc_datapath and encoder_electrical_offset_calibrator.
`default_nettype none

package eeoc_pkg;

   localparam int ANGLE_W     = 14;
   localparam int ERR_W       = 15;
   localparam int AXIS_W      = 3;
   localparam int SUM_W       = ERR_W + 1;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 15;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 80;
   localparam int RSP_BITS    = 2 * ERR_W + 3 * ANGLE_W + AXIS_W + 3;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_BITS;
   localparam int REQ_PAD_W   = REQ_TDATA_W - ANGLE_W;

   typedef logic [ANGLE_W-1:0]       angle_type;
   typedef logic signed [ERR_W-1:0]  err_type;
   typedef logic [AXIS_W-1:0]        axis_type;

   localparam axis_type AXIS_FIRST  = axis_type'(1);
   localparam axis_type AXIS_SECOND = axis_type'(2);
   localparam axis_type AXIS_LAST   = axis_type'(6);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COUNTS_PER_SIXTY_DEG = 1'b0,
      CSR_INDEX_OFFSET         = 1'b1
   } csr_index_type;

   typedef struct packed {
      angle_type counts_per_sixty_deg;
      err_type   index_offset;
   } cfg_type;

   typedef struct packed {
      angle_type angle;
      logic      first_of_run;
      logic      last_of_run;
   } req_type;

   typedef struct packed {
      angle_type prev_angle;
      angle_type first_angle;
      err_type   min_err;
      angle_type max_err;
      axis_type  axis_now;
   } state_type;

   typedef struct packed {
      err_type   delta_error;
      err_type   min_error;
      angle_type max_error;
      logic      index_valid;
      angle_type enc_index;
      angle_type enc_index_offset;
      axis_type  next_axis;
      logic      phase_u_on;
      logic      phase_v_on;
      logic      phase_w_on;
   } rsp_type;

   // Phase enables for an axis, bit 0 = U, bit 1 = V, bit 2 = W.
   function automatic logic [2:0] phase_bits(input axis_type axis);
      logic [2:0] ph;
      unique case (axis)
         3'd1:    ph = 3'b001;
         3'd2:    ph = 3'b011;
         3'd3:    ph = 3'b010;
         3'd4:    ph = 3'b110;
         3'd5:    ph = 3'b100;
         3'd6:    ph = 3'b101;
         default: ph = 3'b000;
      endcase
      return ph;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/encoder_electrical_offset_calibrator.sv
// Top level of the encoder electrical offset calibrator: stream ports, config registers,
// input/result registers and run state. Depends on eeoc_pkg and eeoc_datapath.
`default_nettype none

// Usage:
//   Each request on req_* carries one settled angle reading taken after an axis of the
//   six-step sweep was driven. req_tuser marks the first reading of a run, req_tlast the
//   last. Every request yields exactly one response on rsp_*: the reading's error against
//   the expected counts per 60 electrical degrees, the running min/max error, and the next
//   axis with its phase enables. On the last reading rsp_tlast is high and the response
//   also carries the encoder index and the index plus the configured offset.
//   A request is held in the request register and is presented on rsp_* once it moves
//   into the response register. Throughput: one request per cycle while rsp_tready is high;
//   a request register feeds one pass of subtract, min/max compare and two wrap adds into
//   the response register, and the run state is updated in that same pass for the next reading.
//   Stall: while rsp_tready is low the response holds; one more request is still taken
//   into the request register, after which req_tready drops until the response drains.
//   Reset clears both registers' valid flags, the run state (axis back to the first
//   axis) and both config registers. csr_* writes land at the clock edge with csr_wr_en
//   high; write them only while no request is in flight.

module encoder_electrical_offset_calibrator (
   input  wire                                 clock,
   input  wire                                 reset,
   // request channel
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [eeoc_pkg::REQ_TDATA_W-1:0]    req_tdata,  // [13:0] angle, [15:14] zero
   input  wire                                 req_tuser,  // [0] first_of_run
   input  wire                                 req_tlast,  // last_of_run
   // response channel
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // [14:0] delta_error, [29:15] min_error, [43:30] max_error, [57:44] enc_index,
   // [71:58] enc_index_offset, [74:72] next_axis, [75] phase_u_on, [76] phase_v_on,
   // [77] phase_w_on, [79:78] zero
   output logic [eeoc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast,  // index_valid
   // configuration write port
   input  wire                                 csr_wr_en,
   input  wire  [eeoc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [eeoc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   eeoc_pkg::cfg_type   cfg_ff,       cfg_in;
   eeoc_pkg::state_type state_ff,     state_in;
   eeoc_pkg::req_type   in_ff;
   logic                in_valid_ff,  in_valid_in;
   eeoc_pkg::rsp_type   rsp_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   eeoc_pkg::rsp_type   rsp_next;
   eeoc_pkg::state_type state_next;
   logic                advance;
   logic                req_take;

   // Move the held request into the response register when the response slot frees.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   eeoc_datapath u_datapath (
      .item (in_ff),
      .cur  (state_ff),
      .cfg  (cfg_ff),
      .rsp  (rsp_next),
      .nxt  (state_next)
   );

   // Config register decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (eeoc_pkg::csr_index_type'(csr_index))
            eeoc_pkg::CSR_COUNTS_PER_SIXTY_DEG: begin
               cfg_in.counts_per_sixty_deg = csr_wdata[eeoc_pkg::ANGLE_W-1:0];
            end
            eeoc_pkg::CSR_INDEX_OFFSET: begin
               cfg_in.index_offset = $signed(csr_wdata[eeoc_pkg::ERR_W-1:0]);
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
      state_in     = advance ? state_next : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff             <= '0;
         state_ff           <= '{prev_angle:  '0,
                                 first_angle: '0,
                                 min_err:     '0,
                                 max_err:     '0,
                                 axis_now:    eeoc_pkg::AXIS_FIRST};
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: request on handshake, response on advance; hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff.angle        <= req_tdata[eeoc_pkg::ANGLE_W-1:0];
         in_ff.first_of_run <= req_tuser;
         in_ff.last_of_run  <= req_tlast;
      end
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.index_valid;
   assign rsp_tdata  = {{eeoc_pkg::RSP_PAD_W{1'b0}},
                        rsp_ff.phase_w_on,
                        rsp_ff.phase_v_on,
                        rsp_ff.phase_u_on,
                        rsp_ff.next_axis,
                        rsp_ff.enc_index_offset,
                        rsp_ff.enc_index,
                        rsp_ff.max_error,
                        rsp_ff.min_error,
                        rsp_ff.delta_error};

   // Running minimum never rises above zero.
   a_min_nonpos: assert property (@(posedge clock) disable iff (reset)
      state_ff.min_err == '0 || state_ff.min_err[eeoc_pkg::ERR_W-1])
      else $error("running minimum error above zero");

   // Stored axis stays in the six-step range.
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.axis_now != '0 && state_ff.axis_now <= eeoc_pkg::AXIS_LAST)
      else $error("axis state out of range");

   // Index fields are zero unless the response closes a run.
   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.index_valid |->
         rsp_ff.enc_index == '0 && rsp_ff.enc_index_offset == '0)
      else $error("index fields set on a non-final response");

   // A run start always leads to the second axis.
   a_first_axis: assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.first_of_run |=> rsp_ff.next_axis == eeoc_pkg::AXIS_SECOND)
      else $error("run start did not advance to second axis");

   // Run state moves only when a request reaches the response register.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("run state changed without a request");

endmodule

`default_nettype wire

>>> hw/rtl/eeoc_datapath.sv
// Single-pass combinational datapath: error, running min/max, index and next axis.
// Depends on eeoc_pkg.
`default_nettype none

module eeoc_datapath (
   input  wire eeoc_pkg::req_type   item,
   input  wire eeoc_pkg::state_type cur,
   input  wire eeoc_pkg::cfg_type   cfg,
   output eeoc_pkg::rsp_type        rsp,
   output eeoc_pkg::state_type      nxt
);

   eeoc_pkg::angle_type            delta;
   eeoc_pkg::err_type              err;
   eeoc_pkg::err_type              base_min;
   eeoc_pkg::angle_type            base_max;
   eeoc_pkg::err_type              min_new;
   eeoc_pkg::angle_type            max_new;
   eeoc_pkg::angle_type            first_new;
   logic signed [eeoc_pkg::SUM_W-1:0] sum;
   logic signed [eeoc_pkg::SUM_W-1:0] mid;
   eeoc_pkg::angle_type            idx;
   eeoc_pkg::angle_type            idx_off;
   eeoc_pkg::axis_type             axis_next;
   logic [2:0]                     ph;

   always_comb begin
      // forward delta wraps naturally in the 14-bit subtract
      delta = item.angle - cur.prev_angle;
      if (item.first_of_run) begin
         err       = '0;
         base_min  = '0;
         base_max  = '0;
         first_new = item.angle;
      end else begin
         err       = $signed({1'b0, delta}) - $signed({1'b0, cfg.counts_per_sixty_deg});
         base_min  = cur.min_err;
         base_max  = cur.max_err;
         first_new = cur.first_angle;
      end

      min_new = (err < base_min) ? err : base_min;
      max_new = (err > $signed({1'b0, base_max})) ? err[eeoc_pkg::ANGLE_W-1:0] : base_max;

      // midpoint, truncated toward zero
      sum = $signed({min_new[eeoc_pkg::ERR_W-1], min_new}) + $signed({2'b00, max_new});
      mid = (sum + $signed({{(eeoc_pkg::SUM_W-1){1'b0}}, sum[eeoc_pkg::SUM_W-1]})) >>> 1;

      idx     = first_new + mid[eeoc_pkg::ANGLE_W-1:0];
      idx_off = idx + cfg.index_offset[eeoc_pkg::ANGLE_W-1:0];

      if (item.first_of_run) begin
         axis_next = eeoc_pkg::AXIS_SECOND;
      end else if (cur.axis_now == '0 || cur.axis_now > eeoc_pkg::AXIS_LAST) begin
         axis_next = eeoc_pkg::AXIS_SECOND;
      end else if (cur.axis_now == eeoc_pkg::AXIS_LAST) begin
         axis_next = eeoc_pkg::AXIS_FIRST;
      end else begin
         axis_next = cur.axis_now + eeoc_pkg::AXIS_FIRST;
      end
      ph = eeoc_pkg::phase_bits(axis_next);

      rsp.delta_error      = err;
      rsp.min_error        = min_new;
      rsp.max_error        = max_new;
      rsp.index_valid      = item.last_of_run;
      rsp.enc_index        = item.last_of_run ? idx : '0;
      rsp.enc_index_offset = item.last_of_run ? idx_off : '0;
      rsp.next_axis        = axis_next;
      rsp.phase_u_on       = ph[0];
      rsp.phase_v_on       = ph[1];
      rsp.phase_w_on       = ph[2];

      nxt.prev_angle  = item.angle;
      nxt.first_angle = first_new;
      nxt.min_err     = min_new;
      nxt.max_err     = max_new;
      nxt.axis_now    = axis_next;
   end

endmodule

`default_nettype wire
